[src/geometric_mtf_phasor_sum_core_macros.svh]
// Assertion macros used by the checker file of the MTF phasor block.
`ifndef GEOMETRIC_MTF_PHASOR_SUM_CORE_MACROS_SVH
`define GEOMETRIC_MTF_PHASOR_SUM_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GMPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define GMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/gmps_pkg.sv]
// Shared constants and helper functions of the MTF phasor block.
package gmps_pkg;

    localparam int unsigned MAX_POINTS_DEF = 65536;
    localparam int unsigned TRIG_BITS_DEF  = 16;
    localparam int unsigned FIFO_DEPTH     = 4;

    // Quarter-wave sine polynomial coefficients in Q30.
    localparam logic [30:0] KC1 = 31'd1686629713;
    localparam logic [30:0] KC3 = 31'd693598668;
    localparam logic [30:0] KC5 = 31'd85569306;
    localparam logic [30:0] KC7 = 31'd5026995;
    localparam logic [30:0] KC9 = 31'd172272;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Largest value the point count port can show.
    localparam logic [31:0] PCNT_MAX = 32'd131071;
    localparam logic [16:0] MTF_ONE  = 17'd65536;

    // Round a Q30 magnitude to Q1.15, saturate, and apply the sign.
    function automatic logic signed [15:0] to_q15(input logic [31:0] v, input logic neg);
        logic [32:0] r;
        logic [14:0] mag;
        logic signed [15:0] sval;
        r = ({1'b0, v} + 33'd16384) >> 15;
        if (r > 33'd32767) begin
            mag = 15'h7fff;
        end else begin
            mag = r[14:0];
        end
        sval = $signed({1'b0, mag});
        return neg ? -sval : sval;
    endfunction

endpackage

[src/gmps_fifo.sv]
// Small flip-flop queue between the front and back parts.
module gmps_fifo #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = gmps_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    import gmps_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CNW-1:0] DEPTH_C = CNW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CNW-1:0]   r_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[src/gmps_front.sv]
// Front part: turns each coordinate into a quantized phase and stages it for the queue.
module gmps_front #(
    parameter int unsigned TRIG_BITS = gmps_pkg::TRIG_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [31:0]   i_coordinate,
    input  logic                 i_is_last,
    input  logic [31:0]          i_spatial_frequency,
    output logic                 o_vld,
    output logic [TRIG_BITS-1:0] o_phase,
    output logic                 o_last,
    input  logic                 i_fifo_full
);
    import gmps_pkg::*;

    logic                 r_vld, n_vld;
    logic [TRIG_BITS-1:0] r_phase;
    logic                 r_last;
    logic                 w_ready, w_accept;
    logic signed [64:0]   w_prod;
    logic [39:0]          w_neg;

    // Phase in turns is the fraction of -x*nu, cut to its top bits.
    assign w_prod = $signed(i_coordinate) * $signed({1'b0, i_spatial_frequency});
    assign w_neg  = 40'd0 - w_prod[39:0];

    assign w_ready  = !r_vld || !i_fifo_full;
    assign w_accept = i_push && w_ready;
    assign o_full   = !w_ready;
    assign o_vld    = r_vld;
    assign o_phase  = r_phase;
    assign o_last   = r_last;

    // Stage register holds a request until the queue takes it.
    always_comb begin
        n_vld = r_vld;
        if (w_accept) begin
            n_vld = 1'b1;
        end else if (r_vld && !i_fifo_full) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_phase <= w_neg[39 -: TRIG_BITS];
            r_last  <= i_is_last;
        end
    end

endmodule

[src/gmps_back.sv]
// Back part: sine and cosine on a shared multiplier, accumulation, divide, square root.
module gmps_back #(
    parameter int unsigned MAX_POINTS = gmps_pkg::MAX_POINTS_DEF,
    parameter int unsigned TRIG_BITS  = gmps_pkg::TRIG_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fifo_empty,
    input  logic [TRIG_BITS-1:0] i_phase,
    input  logic                 i_last,
    output logic                 o_fifo_pop,
    input  logic [31:0]          i_spatial_frequency,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [16:0]          o_mtf_value,
    output logic [16:0]          o_point_count
);
    import gmps_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
    localparam int unsigned SW  = $clog2(MAX_POINTS) + 17;
    localparam int unsigned MW  = SW - 1;
    localparam int unsigned DW  = MW + 16;
    localparam int unsigned DCW = $clog2(DW + 1);
    localparam logic [CW-1:0]  MAXC     = CW'(MAX_POINTS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(DW - 1);

    // Polynomial sequencer steps.
    localparam logic [2:0] K_SQUARE = 3'd0;
    localparam logic [2:0] K_C7     = 3'd1;
    localparam logic [2:0] K_C5     = 3'd2;
    localparam logic [2:0] K_C3     = 3'd3;
    localparam logic [2:0] K_C1     = 3'd4;
    localparam logic [2:0] K_FINAL  = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TRIG = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_SQA  = 7'b0001000,
        S_SQB  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state               r_state;
    logic [TRIG_BITS-1:0] r_phase;
    logic                 r_last;
    logic [2:0]           r_k;
    logic                 r_pass;
    logic [30:0]          r_z2;
    logic [30:0]          r_t;
    logic [31:0]          r_sin;
    logic signed [SW-1:0] r_re, r_im;
    logic [CW-1:0]        r_items;
    logic [CW-1:0]        r_cnt;
    logic                 r_zero;
    logic [DW-1:0]        r_dvd_a, r_dvd_b;
    logic [CW-1:0]        r_rem_a, r_rem_b;
    logic [30:0]          r_qa, r_qb;
    logic [DCW-1:0]       r_dcnt;
    logic [62:0]          r_sq, r_res, r_bit;
    logic                 r_out_vld;
    logic [16:0]          r_mtf, r_pcnt;

    logic [30:0]          w_zbase, w_z, w_ma, w_mb, w_coef;
    logic [61:0]          w_prod;
    logic [31:0]          w_hi;
    logic [1:0]           w_quad;
    logic signed [15:0]   w_c, w_s;
    logic signed [SW-1:0] w_re_n, w_im_n;
    logic [CW-1:0]        w_items_n;
    logic [MW-1:0]        w_mag_re, w_mag_im;
    logic [CW:0]          w_rem2_a, w_rem2_b;
    logic                 w_ge_a, w_ge_b;
    logic [62:0]          w_trial;
    logic [32:0]          w_mr33;
    logic [17:0]          w_mr;
    logic [31:0]          w_cnt32;
    logic                 w_out_free;

    // Quadrant angle z in Q30; the second pass uses its complement.
    assign w_zbase = {1'b0, r_phase[TRIG_BITS-3:0], {(32 - TRIG_BITS){1'b0}}};
    assign w_z     = r_pass ? (Q30_ONE - w_zbase) : w_zbase;
    assign w_quad  = r_phase[TRIG_BITS-1 -: 2];

    // Operand selection for the one shared multiplier.
    always_comb begin
        w_ma   = r_t;
        w_mb   = r_z2;
        w_coef = KC1;
        case (r_k)
            K_SQUARE: begin
                w_ma = w_z;
                w_mb = w_z;
            end
            K_C7: begin
                w_ma   = KC9;
                w_coef = KC7;
            end
            K_C5:    w_coef = KC5;
            K_C3:    w_coef = KC3;
            K_C1:    w_coef = KC1;
            K_FINAL: w_mb = w_z;
            default: w_coef = KC1;
        endcase
        if (r_state == S_SQA) begin
            w_ma = r_qa;
            w_mb = r_qa;
        end else if (r_state == S_SQB) begin
            w_ma = r_qb;
            w_mb = r_qb;
        end
    end

    assign w_prod = w_ma * w_mb;
    assign w_hi   = w_prod[61:30];

    // Map the two quarter-wave values onto the full circle.
    always_comb begin
        case (w_quad)
            2'd0: begin
                w_s = to_q15(r_sin, 1'b0);
                w_c = to_q15(w_hi, 1'b0);
            end
            2'd1: begin
                w_s = to_q15(w_hi, 1'b0);
                w_c = to_q15(r_sin, 1'b1);
            end
            2'd2: begin
                w_s = to_q15(r_sin, 1'b1);
                w_c = to_q15(w_hi, 1'b1);
            end
            default: begin
                w_s = to_q15(w_hi, 1'b1);
                w_c = to_q15(r_sin, 1'b0);
            end
        endcase
    end

    // Accumulate unless the count is saturated.
    always_comb begin
        w_re_n    = r_re;
        w_im_n    = r_im;
        w_items_n = r_items;
        if (r_items < MAXC) begin
            w_re_n    = r_re + {{(SW - 16){w_c[15]}}, w_c};
            w_im_n    = r_im + {{(SW - 16){w_s[15]}}, w_s};
            w_items_n = r_items + 1'b1;
        end
    end

    assign w_mag_re = w_re_n[SW-1] ? MW'(-w_re_n) : w_re_n[MW-1:0];
    assign w_mag_im = w_im_n[SW-1] ? MW'(-w_im_n) : w_im_n[MW-1:0];

    // Restoring division steps for both components.
    assign w_rem2_a = {r_rem_a, r_dvd_a[DW-1]};
    assign w_rem2_b = {r_rem_b, r_dvd_b[DW-1]};
    assign w_ge_a   = (w_rem2_a >= {1'b0, r_cnt});
    assign w_ge_b   = (w_rem2_b >= {1'b0, r_cnt});

    // Square root trial value and final rounding.
    assign w_trial = r_res + r_bit;
    assign w_mr33  = {1'b0, r_res[31:0]} + 33'd16384;
    assign w_mr    = w_mr33[32:15];
    assign w_cnt32 = 32'(r_cnt);

    assign w_out_free = !r_out_vld || i_pop;
    assign o_fifo_pop = (r_state == S_IDLE) && !i_fifo_empty;
    assign o_empty       = !r_out_vld;
    assign o_mtf_value   = r_mtf;
    assign o_point_count = r_pcnt;

    // Control state and the running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_re      <= '0;
            r_im      <= '0;
            r_items   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_fifo_empty) begin
                        r_state <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    if (r_k == K_FINAL && r_pass) begin
                        if (r_last) begin
                            r_re    <= '0;
                            r_im    <= '0;
                            r_items <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_re    <= w_re_n;
                            r_im    <= w_im_n;
                            r_items <= w_items_n;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (r_dcnt == DIV_LAST) begin
                        r_state <= S_SQA;
                    end
                end
                S_SQA:  r_state <= S_SQB;
                S_SQB:  r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_phase <= i_phase;
                r_last  <= i_last;
                r_k     <= K_SQUARE;
                r_pass  <= 1'b0;
            end
            S_TRIG: begin
                if (r_k == K_SQUARE) begin
                    r_z2 <= w_hi[30:0];
                    r_k  <= r_k + 1'b1;
                end else if (r_k == K_FINAL) begin
                    r_sin  <= w_hi;
                    r_pass <= 1'b1;
                    r_k    <= K_SQUARE;
                    r_cnt  <= w_items_n;
                    r_zero <= (i_spatial_frequency == 32'd0);
                    r_dvd_a <= {w_mag_re, 16'd0};
                    r_dvd_b <= {w_mag_im, 16'd0};
                    r_rem_a <= '0;
                    r_rem_b <= '0;
                    r_dcnt  <= '0;
                end else begin
                    r_t <= w_coef - w_hi[30:0];
                    r_k <= r_k + 1'b1;
                end
            end
            S_DIV: begin
                r_rem_a <= w_ge_a ? CW'(w_rem2_a - {1'b0, r_cnt}) : w_rem2_a[CW-1:0];
                r_rem_b <= w_ge_b ? CW'(w_rem2_b - {1'b0, r_cnt}) : w_rem2_b[CW-1:0];
                r_qa    <= {r_qa[29:0], w_ge_a};
                r_qb    <= {r_qb[29:0], w_ge_b};
                r_dvd_a <= {r_dvd_a[DW-2:0], 1'b0};
                r_dvd_b <= {r_dvd_b[DW-2:0], 1'b0};
                r_dcnt  <= r_dcnt + 1'b1;
            end
            S_SQA: r_sq <= {1'b0, w_prod};
            S_SQB: begin
                r_sq  <= r_sq + {1'b0, w_prod};
                r_res <= '0;
                r_bit <= {1'b1, 62'd0};
            end
            S_SQRT: begin
                if (r_sq >= w_trial) begin
                    r_sq  <= r_sq - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_OUT: begin
                if (w_out_free) begin
                    if (r_zero || w_mr > 18'd65536) begin
                        r_mtf <= MTF_ONE;
                    end else begin
                        r_mtf <= w_mr[16:0];
                    end
                    r_pcnt <= (w_cnt32 > PCNT_MAX) ? PCNT_MAX[16:0] : w_cnt32[16:0];
                end
            end
            default: r_k <= K_SQUARE;
        endcase
    end

endmodule

[src/geometric_mtf_phasor_sum_core.sv]
// Top level of the geometric MTF phasor-sum block.
// Requests enter through push/full and results leave through empty/pop; the
// frequency register may only be written while the block is idle. For each
// coordinate the back part pops the queue, then makes two polynomial passes
// (one per quarter-wave value) through the single shared 31x31 multiplier
// that evaluates the sine and cosine polynomials, and finishes before it pops
// the next coordinate. A request marked last then runs the two parallel
// dividers, one bit per cycle over the dividend width DW (48 at the default
// MAX_POINTS), squares both quotients, takes 32 square root steps and
// registers the output. A four-entry queue and a front stage register let
// pushes continue while the back part works or a result waits to be popped.
module geometric_mtf_phasor_sum_core #(
    parameter int unsigned MAX_POINTS = gmps_pkg::MAX_POINTS_DEF,
    parameter int unsigned TRIG_BITS  = gmps_pkg::TRIG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_coordinate,
    input  logic               i_is_last,
    output logic               empty,
    input  logic               pop,
    output logic [16:0]        o_mtf_value,
    output logic [16:0]        o_point_count,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data
);
    import gmps_pkg::*;

    logic [31:0]          r_spatial_frequency;
    logic                 w_fr_vld, w_fr_last, w_fifo_full, w_fifo_empty, w_pop;
    logic [TRIG_BITS-1:0] w_fr_phase;
    logic [TRIG_BITS:0]   w_rd_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spatial_frequency <= '0;
        end else if (i_cfg_wr_en) begin
            r_spatial_frequency <= i_cfg_wr_data;
        end
    end

    gmps_front #(.TRIG_BITS(TRIG_BITS)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_coordinate        (i_coordinate),
        .i_is_last           (i_is_last),
        .i_spatial_frequency (r_spatial_frequency),
        .o_vld               (w_fr_vld),
        .o_phase             (w_fr_phase),
        .o_last              (w_fr_last),
        .i_fifo_full         (w_fifo_full)
    );

    gmps_fifo #(.WIDTH(TRIG_BITS + 1), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fr_vld),
        .i_wdata ({w_fr_last, w_fr_phase}),
        .o_full  (w_fifo_full),
        .i_rd    (w_pop),
        .o_rdata (w_rd_data),
        .o_empty (w_fifo_empty)
    );

    gmps_back #(.MAX_POINTS(MAX_POINTS), .TRIG_BITS(TRIG_BITS)) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fifo_empty        (w_fifo_empty),
        .i_phase             (w_rd_data[TRIG_BITS-1:0]),
        .i_last              (w_rd_data[TRIG_BITS]),
        .o_fifo_pop          (w_pop),
        .i_spatial_frequency (r_spatial_frequency),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_mtf_value         (o_mtf_value),
        .o_point_count       (o_point_count)
    );

endmodule

[src/gmps_checker.sv]
// Port-level checker for the MTF phasor block and its bind statement.
`include "geometric_mtf_phasor_sum_core_macros.svh"

module gmps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic [16:0]        o_mtf_value,
    input logic [16:0]        o_point_count
);
    import gmps_pkg::*;

    // A shown result never exceeds 1.0 and always counts at least one point.
    `GMPS_ASSERT(a_mtf_range, i_clk, i_rst_n, !empty |-> o_mtf_value <= MTF_ONE, "mtf above one")
    `GMPS_ASSERT(a_cnt_nonzero, i_clk, i_rst_n, !empty |-> o_point_count != 17'd0, "zero count")
    // A result that is not popped stays in place.
    `GMPS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_mtf_value) && $stable(o_point_count), "result changed while waiting")

endmodule

bind geometric_mtf_phasor_sum_core gmps_checker u_gmps_checker (.*);
